>>> rtl/binomial_downsample_by_two_assert.svh
// Assertion macros used by the port-level checker.
`ifndef BINOMIAL_DOWNSAMPLE_BY_TWO_ASSERT_SVH
`define BINOMIAL_DOWNSAMPLE_BY_TWO_ASSERT_SVH

// Same-cycle implication, off while reset is active
`define BDDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is active
`define BDDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs during reset
`define BDDS_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bdds_pkg.sv
`default_nettype none
package bdds_pkg;

    // Parameter defaults
    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LINE_ROWS_DEF   = 6;

    // Fixed field widths
    localparam int OUT_BITS      = 16;
    localparam int COL_OUT_BITS  = 11;
    localparam int ROW_OUT_BITS  = 15;
    localparam int WIDTH_BITS    = 13;
    localparam int HEIGHT_BITS   = 16;
    localparam int MODE_BITS     = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int CHANNELS      = 3;
    localparam int WSUM_BITS     = 11;
    localparam int SPAN_BITS     = 17;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd2;

    // Stencil modes
    localparam logic [MODE_BITS-1:0] MODE_BOX  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_TAP4 = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_TAP6 = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_RSVD = 2'd3;

    // 1-D binomial weights, one row per mode
    localparam logic [3:0] TAP_WT [0:2][0:5] = '{
        '{4'd1, 4'd1, 4'd0,  4'd0,  4'd0, 4'd0},
        '{4'd1, 4'd3, 4'd3,  4'd1,  4'd0, 4'd0},
        '{4'd1, 4'd5, 4'd10, 4'd10, 4'd5, 4'd1}
    };

    typedef struct packed {
        logic [1:0]           cnt;
        logic [SPAN_BITS-1:0] first;
    } t_span;

    // Last tap offset of a mode
    function automatic logic [2:0] tap_hi(input logic [MODE_BITS-1:0] mode);
        logic [2:0] h;
        unique case (mode)
            MODE_BOX:  h = 3'd1;
            MODE_TAP4: h = 3'd2;
            default:   h = 3'd3;
        endcase
        return h;
    endfunction

    // Low indices whose clipped window ends at high coordinate p of extent n
    function automatic t_span low_span(input logic [SPAN_BITS-1:0] p,
                                       input logic [SPAN_BITS-1:0] n,
                                       input logic [2:0] hi);
        logic [SPAN_BITS-1:0] hx;
        logic [SPAN_BITS-1:0] lown;
        logic [SPAN_BITS-1:0] f;
        t_span s;
        hx = SPAN_BITS'(hi);
        lown = (n + SPAN_BITS'(1)) >> 1;
        s.cnt = 2'd0;
        s.first = '0;
        f = '0;
        if (p + SPAN_BITS'(1) == n) begin
            f = (n - SPAN_BITS'(1) <= hx) ? '0 : ((n - hx) >> 1);
            s.first = f;
            s.cnt = (f < lown) ? 2'(lown - f) : 2'd0;
        end else if (p >= hx && (p[0] == hx[0])) begin
            s.first = (p - hx) >> 1;
            s.cnt = 2'd1;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

>>> rtl/bdds_if.sv
`default_nettype none
// Pixel input channel
interface bdds_pix_if #(parameter int SAMPLE_BITS = bdds_pkg::SAMPLE_BITS_DEF);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_red;
    logic [SAMPLE_BITS-1:0] sample_green;
    logic [SAMPLE_BITS-1:0] sample_blue;
    modport source (output valid, sample_red, sample_green, sample_blue, input ready);
    modport sink   (input valid, sample_red, sample_green, sample_blue, output ready);
endinterface

// Low pixel result channel
interface bdds_res_if;
    logic                              valid;
    logic                              ready;
    logic [bdds_pkg::OUT_BITS-1:0]     out_red;
    logic [bdds_pkg::OUT_BITS-1:0]     out_green;
    logic [bdds_pkg::OUT_BITS-1:0]     out_blue;
    logic [bdds_pkg::COL_OUT_BITS-1:0] out_col;
    logic [bdds_pkg::ROW_OUT_BITS-1:0] out_row;
    logic                              last_of_run;
    logic                              frame_done;
    modport source (output valid, out_red, out_green, out_blue, out_col, out_row,
                    last_of_run, frame_done, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_col, out_row,
                    last_of_run, frame_done, output ready);
endinterface

// Register write channel
interface bdds_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bdds_pkg::CFG_IDX_BITS-1:0]  reg_index;
    logic [bdds_pkg::CFG_DATA_BITS-1:0] data;
    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/bdds_ram.sv
`default_nettype none
// Simple dual-port RAM, registered read
module bdds_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/bdds_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, all channels in parallel
module bdds_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 11
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_start,
    input  wire logic [bdds_pkg::CHANNELS-1:0][NUM_W-1:0]     i_num,
    input  wire logic [DEN_W-1:0]                             i_den,
    output      logic [bdds_pkg::CHANNELS-1:0][NUM_W-1:0]     o_quo,
    output      logic                                         o_busy
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [bdds_pkg::CHANNELS-1:0][NUM_W-1:0] r_nq;
    logic [bdds_pkg::CHANNELS-1:0][DEN_W-1:0] r_rem;
    logic [DEN_W-1:0]                         r_den;
    logic [CNT_W-1:0]                         r_cnt;
    logic                                     r_busy;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    // Datapath: shift numerator into remainder, shift quotient bit in
    always_ff @(posedge i_clk) begin
        logic [DEN_W:0] trial;
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            for (int c = 0; c < bdds_pkg::CHANNELS; c++) begin
                trial = {r_rem[c], r_nq[c][NUM_W-1]};
                if (trial >= {1'b0, r_den}) begin
                    r_rem[c] <= DEN_W'(trial - {1'b0, r_den});
                    r_nq[c]  <= {r_nq[c][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[c] <= DEN_W'(trial);
                    r_nq[c]  <= {r_nq[c][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo  = r_nq;
    assign o_busy = r_busy;
endmodule
`default_nettype wire

>>> rtl/binomial_downsample_by_two.sv
// Binomial 2x down-sampler. Takes RGB pixels in raster order and emits the
// half-size image, each low pixel the rounded weighted mean of a 2-, 4- or
// 6-tap separable binomial window clipped at the image edges. Every input
// pixel is written to a line memory of LINE_ROWS x MAX_WIDTH words in its
// accept cycle; an input that completes no window is done in that cycle.
// Each low pixel it completes (up to four, in raster order) is built from
// line memory reads, one per window tap over its single read port (T*T
// taps, T = 2, 4 or 6); the sum then settles through the drain and load
// states, the bit-serial divider runs and the result is handed over.
// New input is taken once the last result of the previous pixel sits in
// the output register. The line memory needs no clearing after reset.
// The user must write registers while idle; the block does not enforce it.
`default_nettype none
module binomial_downsample_by_two #(
    parameter int MAX_WIDTH   = bdds_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = bdds_pkg::SAMPLE_BITS_DEF,
    parameter int LINE_ROWS   = bdds_pkg::LINE_ROWS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    bdds_pix_if.sink    i_pix,
    bdds_res_if.source  o_res,
    bdds_cfg_if.sink    i_cfg
);
    localparam int HW     = bdds_pkg::HEIGHT_BITS;
    localparam int SPW    = bdds_pkg::SPAN_BITS;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WE     = $clog2(MAX_WIDTH + 1);
    localparam int SW     = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
    localparam int SLW    = $clog2(3 * LINE_ROWS);
    localparam int DEPTH  = LINE_ROWS * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int ACC_W  = SAMPLE_BITS + 10;
    localparam int NUM_W  = SAMPLE_BITS + 11;
    localparam int DEN_W  = bdds_pkg::WSUM_BITS;
    localparam int CCW    = COL_W + 3;
    localparam int RRW    = HW + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAP   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]                          r_state;
    logic [bdds_pkg::MODE_BITS-1:0]      r_mode;
    logic [bdds_pkg::WIDTH_BITS-1:0]     r_img_w;
    logic [HW-1:0]                       r_img_h;
    logic [COL_W-1:0]                    r_col;
    logic [HW-1:0]                       r_row;
    logic [SW-1:0]                       r_slot;
    logic [HW-1:0]                       r_cur_row;
    logic [SW-1:0]                       r_cur_slot;
    logic [COL_W-1:0]                    r_i0;
    logic [HW-1:0]                       r_j0;
    logic [1:0]                          r_ni;
    logic [1:0]                          r_nj;
    logic                                r_a;
    logic                                r_b;
    logic [2:0]                          r_l;
    logic [2:0]                          r_k;
    logic                                r_pv;
    logic [6:0]                          r_pw;
    logic [bdds_pkg::CHANNELS-1:0][ACC_W-1:0] r_acc;
    logic [DEN_W-1:0]                    r_wsum;
    logic                                r_ov;
    logic [bdds_pkg::OUT_BITS-1:0]       r_o_red;
    logic [bdds_pkg::OUT_BITS-1:0]       r_o_green;
    logic [bdds_pkg::OUT_BITS-1:0]       r_o_blue;
    logic [bdds_pkg::COL_OUT_BITS-1:0]   r_o_col;
    logic [bdds_pkg::ROW_OUT_BITS-1:0]   r_o_row;
    logic                                r_o_last;
    logic                                r_o_frame;

    // Effective stencil and image extent
    logic [bdds_pkg::MODE_BITS-1:0] mode_n;
    logic [2:0]                     hi;
    logic [2:0]                     ntaps;
    logic [2:0]                     loff;
    logic [WE-1:0]                  w_eff;
    logic [HW-1:0]                  h_eff;

    always_comb begin
        mode_n = (r_mode == bdds_pkg::MODE_RSVD) ? bdds_pkg::MODE_TAP6 : r_mode;
        hi     = bdds_pkg::tap_hi(mode_n);
        ntaps  = {hi[1:0], 1'b0};
        loff   = hi - 3'd1;
        if (r_img_w == '0) begin
            w_eff = WE'(1);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w_eff = WE'(MAX_WIDTH);
        end else begin
            w_eff = WE'(r_img_w);
        end
        h_eff = (r_img_h == '0) ? HW'(1) : r_img_h;
    end

    // Position of the accepted pixel, and the position after it
    logic             accept;
    logic             col_ge;
    logic [HW:0]      row_a;
    logic [SW-1:0]    slot_a;
    logic             row_wrap;
    logic [COL_W-1:0] p_col;
    logic [HW-1:0]    p_row;
    logic [SW-1:0]    p_slot;
    logic [WE-1:0]    col1;
    logic             col1_ge;
    logic [HW:0]      row_b;
    logic [COL_W-1:0] q_col;
    logic [HW-1:0]    q_row;
    logic [SW-1:0]    q_slot;
    bdds_pkg::t_span  span_c;
    bdds_pkg::t_span  span_r;

    assign accept = i_pix.valid && (r_state == S_IDLE);

    always_comb begin
        col_ge   = WE'(r_col) >= w_eff;
        row_a    = col_ge ? (HW+1)'(r_row) + (HW+1)'(1) : (HW+1)'(r_row);
        if (col_ge) begin
            slot_a = (r_slot == SW'(LINE_ROWS - 1)) ? '0 : r_slot + SW'(1);
        end else begin
            slot_a = r_slot;
        end
        row_wrap = row_a >= (HW+1)'(h_eff);
        p_col    = col_ge ? '0 : r_col;
        p_row    = row_wrap ? '0 : HW'(row_a);
        p_slot   = row_wrap ? '0 : slot_a;

        col1     = WE'(p_col) + WE'(1);
        col1_ge  = col1 >= w_eff;
        row_b    = (HW+1)'(p_row) + (HW+1)'(1);
        q_col    = col1_ge ? '0 : COL_W'(col1);
        q_row    = p_row;
        q_slot   = p_slot;
        if (col1_ge) begin
            if (row_b >= (HW+1)'(h_eff)) begin
                q_row  = '0;
                q_slot = '0;
            end else begin
                q_row  = HW'(row_b);
                q_slot = (p_slot == SW'(LINE_ROWS - 1)) ? '0 : p_slot + SW'(1);
            end
        end

        span_c = bdds_pkg::low_span(SPW'(p_col), SPW'(w_eff), hi);
        span_r = bdds_pkg::low_span(SPW'(p_row), SPW'(h_eff), hi);
    end

    // Tap address and weight for the current window position
    logic [COL_W-1:0]        li;
    logic [HW-1:0]           lj;
    logic signed [CCW-1:0]   cc;
    logic signed [RRW-1:0]   rr;
    logic                    c_in;
    logic                    r_in;
    logic [2:0]              row_back;
    logic [SLW-1:0]          t0;
    logic [SLW-1:0]          t1;
    logic [SLW-1:0]          t2;
    logic [SW-1:0]           rslot;
    logic [AW-1:0]           raddr;
    logic [AW-1:0]           waddr;
    logic [6:0]              wt;
    logic                    k_last;
    logic                    l_last;

    always_comb begin
        li     = r_i0 + COL_W'(r_a);
        lj     = r_j0 + HW'(r_b);
        cc     = $signed({2'b00, li, 1'b0}) + $signed(CCW'(r_k)) - $signed(CCW'(loff));
        rr     = $signed({1'b0, lj, 1'b0}) + $signed(RRW'(r_l)) - $signed(RRW'(loff));
        c_in   = !cc[CCW-1] && ($unsigned(cc) < CCW'(w_eff));
        r_in   = !rr[RRW-1] && ($unsigned(rr) < RRW'(h_eff));
        row_back = 3'(r_cur_row - rr[HW-1:0]);
        // slot of the tap row, back from the current row's slot
        t0     = SLW'(r_cur_slot) + SLW'(2 * LINE_ROWS) - SLW'(row_back);
        t1     = (t0 >= SLW'(LINE_ROWS)) ? t0 - SLW'(LINE_ROWS) : t0;
        t2     = (t1 >= SLW'(LINE_ROWS)) ? t1 - SLW'(LINE_ROWS) : t1;
        rslot  = SW'(t2);
        raddr  = AW'(AW'(rslot) * AW'(MAX_WIDTH)) + AW'(cc[COL_W-1:0]);
        waddr  = AW'(AW'(p_slot) * AW'(MAX_WIDTH)) + AW'(p_col);
        wt     = 7'(8'(bdds_pkg::TAP_WT[mode_n][r_l]) * 8'(bdds_pkg::TAP_WT[mode_n][r_k]));
        k_last = (r_k == ntaps - 3'd1);
        l_last = (r_l == ntaps - 3'd1);
    end

    // Line memory
    logic [3*SAMPLE_BITS-1:0] rdata;

    bdds_ram #(
        .WIDTH (3 * SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (waddr),
        .i_wdata ({i_pix.sample_blue, i_pix.sample_green, i_pix.sample_red}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Divider
    logic                                     div_start;
    logic                                     div_busy;
    logic [bdds_pkg::CHANNELS-1:0][NUM_W-1:0] div_num;
    logic [bdds_pkg::CHANNELS-1:0][NUM_W-1:0] div_quo;

    assign div_start = (r_state == S_LOAD);

    always_comb begin
        for (int c = 0; c < bdds_pkg::CHANNELS; c++) begin
            div_num[c] = NUM_W'(r_acc[c]) + NUM_W'(r_wsum >> 1);
        end
    end

    bdds_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_wsum),
        .o_quo   (div_quo),
        .o_busy  (div_busy)
    );

    logic out_free;
    logic a_last;
    logic b_last;

    assign out_free = !r_ov || o_res.ready;
    assign a_last   = ({1'b0, r_a} + 2'd1) == r_ni;
    assign b_last   = ({1'b0, r_b} + 2'd1) == r_nj;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bdds_pkg::MODE_BOX;
            r_img_w <= bdds_pkg::WIDTH_BITS'(4096);
            r_img_h <= HW'(4096);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                bdds_pkg::CFG_MODE:   r_mode  <= i_cfg.data[bdds_pkg::MODE_BITS-1:0];
                bdds_pkg::CFG_WIDTH:  r_img_w <= i_cfg.data[bdds_pkg::WIDTH_BITS-1:0];
                bdds_pkg::CFG_HEIGHT: r_img_h <= i_cfg.data[HW-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: window reads, divide, hand over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_slot  <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            r_pv <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_col <= q_col;
                        r_row <= q_row;
                        r_slot <= q_slot;
                        if (span_c.cnt != 2'd0 && span_r.cnt != 2'd0) begin
                            r_state <= S_TAP;
                        end
                    end
                end
                S_TAP: begin
                    r_pv <= c_in && r_in;
                    if (k_last) begin
                        if (l_last) begin
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: r_state <= S_LOAD;
                S_LOAD:  r_state <= S_DIV;
                S_DIV: begin
                    if (!div_busy) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_state <= (a_last && b_last) ? S_IDLE : S_TAP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_pv) begin
            r_acc[0] <= r_acc[0] + ACC_W'(rdata[SAMPLE_BITS-1:0]) * ACC_W'(r_pw);
            r_acc[1] <= r_acc[1]
                      + ACC_W'(rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) * ACC_W'(r_pw);
            r_acc[2] <= r_acc[2]
                      + ACC_W'(rdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]) * ACC_W'(r_pw);
        end
        unique case (r_state)
            S_IDLE: begin
                r_cur_row  <= p_row;
                r_cur_slot <= p_slot;
                r_i0       <= COL_W'(span_c.first);
                r_j0       <= HW'(span_r.first);
                r_ni       <= span_c.cnt;
                r_nj       <= span_r.cnt;
                r_a        <= 1'b0;
                r_b        <= 1'b0;
                r_l        <= '0;
                r_k        <= '0;
                r_acc      <= '0;
                r_wsum     <= '0;
            end
            S_TAP: begin
                r_pw <= wt;
                if (c_in && r_in) begin
                    r_wsum <= r_wsum + DEN_W'(wt);
                end
                if (k_last) begin
                    r_k <= '0;
                    r_l <= r_l + 3'd1;
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_o_red   <= (r_wsum == '0) ? '0 : bdds_pkg::OUT_BITS'(div_quo[0]);
                    r_o_green <= (r_wsum == '0) ? '0 : bdds_pkg::OUT_BITS'(div_quo[1]);
                    r_o_blue  <= (r_wsum == '0) ? '0 : bdds_pkg::OUT_BITS'(div_quo[2]);
                    r_o_col   <= bdds_pkg::COL_OUT_BITS'(li);
                    r_o_row   <= bdds_pkg::ROW_OUT_BITS'(lj);
                    r_o_last  <= a_last && b_last;
                    r_o_frame <= ((WE+1)'(li) + (WE+1)'(1) == ((WE+1)'(w_eff) + (WE+1)'(1)) >> 1)
                              && ((HW+1)'(lj) + (HW+1)'(1) == ((HW+1)'(h_eff) + (HW+1)'(1)) >> 1);
                    // next low pixel of this run, raster order
                    r_l    <= '0;
                    r_k    <= '0;
                    r_acc  <= '0;
                    r_wsum <= '0;
                    if (a_last) begin
                        r_a <= 1'b0;
                        r_b <= r_b + 1'b1;
                    end else begin
                        r_a <= r_a + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign i_pix.ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = r_ov;
    assign o_res.out_red     = r_o_red;
    assign o_res.out_green   = r_o_green;
    assign o_res.out_blue    = r_o_blue;
    assign o_res.out_col     = r_o_col;
    assign o_res.out_row     = r_o_row;
    assign o_res.last_of_run = r_o_last;
    assign o_res.frame_done  = r_o_frame;
endmodule
`default_nettype wire

>>> rtl/bdds_chk.sv
`default_nettype none
`include "binomial_downsample_by_two_assert.svh"
// Port-level checks for the down-sampler
module bdds_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_last,
    input wire logic out_frame
);
    // a stalled word stays offered
    `BDDS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    // the frame's final pixel closes its run
    `BDDS_ASSERT_IMP(a_frame_last, i_clk, i_rst_n, out_valid && out_frame, out_last, "frame_done without last_of_run")
    // no new pixel while a run is still being produced
    `BDDS_ASSERT_IMP(a_busy_run, i_clk, i_rst_n, out_valid && !out_last, !in_ready, "input taken mid-run")
    // reset empties the output register
    `BDDS_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !out_valid, "output valid after reset")
endmodule

bind binomial_downsample_by_two bdds_chk u_bdds_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_pix.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_last  (o_res.last_of_run),
    .out_frame (o_res.frame_done)
);
`default_nettype wire

>>> sim/bdds_checker.sv
`default_nettype none
module bdds_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bdds_pix_if       pix,
    bdds_res_if       res,
    bdds_cfg_if       cfg,
    output int        o_errors,
    output int        o_checked,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW  = bdds_pkg::MAX_WIDTH_DEF;
    localparam int NROWS = bdds_pkg::LINE_ROWS_DEF;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [10:0] col;
        logic [14:0] row;
        logic        last;
        logic        done;
    } t_low_pixel;

    // 1-D binomial weights per stencil
    int weight [3][6] = '{'{1, 1, 0, 0, 0, 0}, '{1, 3, 3, 1, 0, 0},
                          '{1, 5, 10, 10, 5, 1}};
    int tap_first [3] = '{0, -1, -2};
    int tap_last  [3] = '{1, 2, 3};

    logic [47:0] line_mem [NROWS*MAXW];
    logic [1:0]  mode_reg;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    int          col_pos;
    int          row_pos;
    t_low_pixel  awaited_pixels [$];

    assign o_pending = awaited_pixels.size();

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    // Low indices whose clipped window ends at high coordinate p of extent n
    function automatic void window_span(input int p, input int n, input int hi,
                                        output int first, output int cnt);
        int lown;
        lown = (n + 1) / 2;
        first = 0;
        cnt = 0;
        if (p + 1 == n) begin
            first = (n - 1 <= hi) ? 0 : (n - hi) / 2;
            cnt = (first < lown) ? lown - first : 0;
        end else if (p >= hi && ((p - hi) % 2) == 0) begin
            first = (p - hi) / 2;
            cnt = 1;
        end
    endfunction

    // Store one high pixel and queue the low pixels it completes
    function automatic void predict_low_pixels(input logic [47:0] px);
        int m, w, h, hi, i0, ni, j0, nj, rr, cc, wt, n;
        longint acc [3];
        longint wsum;
        t_low_pixel lp;
        m = (mode_reg > 2) ? 2 : int'(mode_reg);
        w = (width_reg == 0) ? 1 : (width_reg > MAXW ? MAXW : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        hi = tap_last[m];
        n = 0;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        line_mem[(row_pos % NROWS) * MAXW + col_pos] = px;
        window_span(row_pos, h, hi, j0, nj);
        window_span(col_pos, w, hi, i0, ni);
        for (int b = 0; b < nj; b++) begin
            for (int a = 0; a < ni; a++) begin
                acc = '{0, 0, 0};
                wsum = 0;
                for (int l = tap_first[m]; l <= hi; l++) begin
                    rr = (j0 + b) * 2 + l;
                    if (rr < 0 || rr >= h) continue;
                    for (int k = tap_first[m]; k <= hi; k++) begin
                        cc = (i0 + a) * 2 + k;
                        if (cc < 0 || cc >= w) continue;
                        wt = weight[m][l - tap_first[m]] * weight[m][k - tap_first[m]];
                        for (int c = 0; c < 3; c++)
                            acc[c] += longint'(line_mem[(rr % NROWS) * MAXW + cc]
                                               [c*16 +: 16]) * wt;
                        wsum += wt;
                    end
                end
                lp.blue  = 16'((acc[0] + wsum / 2) / wsum);
                lp.green = 16'((acc[1] + wsum / 2) / wsum);
                lp.red   = 16'((acc[2] + wsum / 2) / wsum);
                lp.col   = 11'(i0 + a);
                lp.row   = 15'(j0 + b);
                lp.last  = (b == nj - 1) && (a == ni - 1);
                lp.done  = (i0 + a + 1 == (w + 1) / 2) && (j0 + b + 1 == (h + 1) / 2);
                awaited_pixels.push_back(lp);
            end
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        t_low_pixel exp_px;
        if (!i_rst_n) begin
            mode_reg   <= bdds_pkg::MODE_BOX;
            width_reg  <= 13'd4096;
            height_reg <= 16'd4096;
            col_pos = 0;
            row_pos = 0;
            awaited_pixels.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.reg_index)
                    bdds_pkg::CFG_MODE:
                        mode_reg   <= cfg.data[bdds_pkg::MODE_BITS-1:0];
                    bdds_pkg::CFG_WIDTH:
                        width_reg  <= cfg.data[bdds_pkg::WIDTH_BITS-1:0];
                    bdds_pkg::CFG_HEIGHT:
                        height_reg <= cfg.data[bdds_pkg::HEIGHT_BITS-1:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
                predict_low_pixels({pix.sample_red, pix.sample_green, pix.sample_blue});
            // compare each result word against the oldest prediction
            if (res.valid && res.ready) begin
                o_checked++;
                if (awaited_pixels.size() == 0) begin
                    report($sformatf("unexpected low pixel col %0d row %0d",
                                     res.out_col, res.out_row));
                end else begin
                    exp_px = awaited_pixels.pop_front();
                    if (res.out_red !== exp_px.red)
                        report($sformatf("red %h, want %h", res.out_red, exp_px.red));
                    if (res.out_green !== exp_px.green)
                        report($sformatf("green %h, want %h", res.out_green, exp_px.green));
                    if (res.out_blue !== exp_px.blue)
                        report($sformatf("blue %h, want %h", res.out_blue, exp_px.blue));
                    if (res.out_col !== exp_px.col)
                        report($sformatf("col %0d, want %0d", res.out_col, exp_px.col));
                    if (res.out_row !== exp_px.row)
                        report($sformatf("row %0d, want %0d", res.out_row, exp_px.row));
                    if (res.last_of_run !== exp_px.last)
                        report($sformatf("last_of_run %b, want %b", res.last_of_run,
                                         exp_px.last));
                    if (res.frame_done !== exp_px.done)
                        report($sformatf("frame_done %b, want %b", res.frame_done,
                                         exp_px.done));
                end
            end
        end
    end

    initial begin
        o_errors = 0;
        o_checked = 0;
    end
endmodule
`default_nettype wire

>>> sim/tb_binomial_downsample_by_two.sv
`default_nettype none
module tb_binomial_downsample_by_two;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    bit   quiet;
    int   errors, checked, pending, pixels_sent, frames_run, stall_left;

    bdds_pix_if pix_ch ();
    bdds_res_if res_ch ();
    bdds_cfg_if cfg_ch ();

    binomial_downsample_by_two DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    bdds_checker checker_i (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .pix       (pix_ch),
        .res       (res_ch),
        .cfg       (cfg_ch),
        .o_errors  (errors),
        .o_checked (checked),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) res_ch.ready <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left <= $urandom_range(1, 9);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [bdds_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.sample_red <= r;
        pix_ch.sample_green <= g;
        pix_ch.sample_blue <= b;
        do @(posedge i_clk); while (!pix_ch.ready);
        pixels_sent++;
    endtask

    // Drain all results, then allow the pipeline to go quiet
    task automatic settle();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic feed(input int count);
        for (int n = 0; n < count; n++) send_pixel(pick_sample(), pick_sample(), pick_sample());
    endtask

    // One full frame; raw register words, effective size derived as the block does
    task automatic run_frame(input logic [15:0] mode, input logic [15:0] wd,
                             input logic [15:0] ht);
        int w, h;
        w = (wd[12:0] == 0) ? 1 : (wd[12:0] > 4096 ? 4096 : int'(wd[12:0]));
        h = (ht == 0) ? 1 : int'(ht);
        write_reg(bdds_pkg::CFG_MODE, mode);
        write_reg(bdds_pkg::CFG_WIDTH, wd);
        write_reg(bdds_pkg::CFG_HEIGHT, ht);
        feed(w * h);
        settle();
        frames_run++;
    endtask

    initial begin
        int start_px;
        i_rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.sample_red = '0;
        pix_ch.sample_green = '0;
        pix_ch.sample_blue = '0;
        res_ch.ready = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = bdds_pkg::CFG_MODE;
        cfg_ch.data = '0;
        quiet = 1'b0;
        stall_left = 0;
        pixels_sent = 0;
        frames_run = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero sizes act as one, extreme samples
        write_reg(bdds_pkg::CFG_MODE, {14'h0, bdds_pkg::MODE_BOX});
        write_reg(bdds_pkg::CFG_WIDTH, 16'h0000);
        write_reg(bdds_pkg::CFG_HEIGHT, 16'h0000);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        settle();
        run_frame(16'h0000, 16'h0002, 16'h0002);
        run_frame(16'h0001, 16'h0003, 16'h0003);
        run_frame(16'h0002, 16'hE005, 16'h0004);
        // unused mode behaves as 6-tap; upper data bits are ignored
        run_frame(16'hFFFF, 16'h0004, 16'h0003);
        // tallest height, then shrink it mid-frame and finish as a 5-row frame
        write_reg(bdds_pkg::CFG_MODE, {14'h0, bdds_pkg::MODE_TAP6});
        write_reg(bdds_pkg::CFG_WIDTH, 16'h0001);
        write_reg(bdds_pkg::CFG_HEIGHT, 16'hFFFF);
        feed(4);
        settle();
        write_reg(bdds_pkg::CFG_HEIGHT, 16'h0005);
        feed(1);
        settle();

        // Random frames of small size
        start_px = pixels_sent;
        while (pixels_sent - start_px < 410) begin
            if (pixels_sent - start_px > 330) quiet = 1'b1;
            run_frame(16'($urandom), 16'($urandom_range(1, 14)) | 16'($urandom) & 16'hE000,
                      16'($urandom_range(1, 10)));
        end

        $display("Ran %0d pixels over %0d frames, %0d low pixels checked", pixels_sent,
                 frames_run, checked);
        $display("Covered all stencils, clipped edges, size extremes and a mid-frame resize");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
